// ===== rtl/core/yarn_speed_ratio_regulator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Yarn speed ratio regulator assertion macros
// Immediate-implication and next-cycle checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef YARN_SPEED_RATIO_REGULATOR_CORE_ASSERT_SVH
`define YARN_SPEED_RATIO_REGULATOR_CORE_ASSERT_SVH

// hold cons in the same cycle as ante
`define YSRR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ysrr check failed");

// hold cons in the cycle after ante
`define YSRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ysrr check failed");

`endif

// ===== rtl/core/ysrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Yarn speed ratio regulator package
// Sequencer states, motor codes, register indexes, history depth and register
// reset values.
// ----------------------------------------------------------------------------
package ysrr_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATIO,
      ST_DEV,
      ST_WRITE,
      ST_AVG,
      ST_CTRL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_LOCKED = 2'd0,
      MODE_LEFT   = 2'd1,
      MODE_RIGHT  = 2'd2
   } motor_mode_type;

   typedef enum logic [2:0] {
      REG_START_DELAY = 3'd0,
      REG_FAULT_DELAY = 3'd1,
      REG_UP_THR      = 3'd2,
      REG_DOWN_THR    = 3'd3,
      REG_LEFT_STEP   = 3'd4,
      REG_RIGHT_STEP  = 3'd5,
      REG_PAUSE       = 3'd6,
      REG_OVERFEED    = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   // ring depth, a power of two so the average is a shift
   localparam int HISTORY_DEPTH = 64;
   localparam int HIST_SHIFT    = $clog2(HISTORY_DEPTH);

   localparam logic        [7:0]  START_DELAY_RST = 8'd5;
   localparam logic        [15:0] FAULT_DELAY_RST = 16'd1200;
   localparam logic        [23:0] UP_THR_RST      = 24'd83886;
   localparam logic signed [24:0] DOWN_THR_RST    = -25'sd83886;
   localparam logic        [7:0]  LEFT_STEP_RST   = 8'd4;
   localparam logic        [7:0]  RIGHT_STEP_RST  = 8'd4;
   localparam logic        [7:0]  PAUSE_RST       = 8'd32;
   localparam logic signed [24:0] OVERFEED_RST    = 25'sd0;

endpackage

// ===== rtl/core/yarn_speed_ratio_regulator_core.sv =====
// ----------------------------------------------------------------------------
// Yarn speed ratio regulator core
// Per-tick ratio deviation, ring average held in a synchronous memory,
// dead band motor control with step, pause and fault timers.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              contents
//  req_      in    req_tvalid/req_tready  running, count_a, count_b
//  rsp_      out   rsp_tvalid/rsp_tready  led, fault_pin, motor_cmd, stepping, avg
//  csr_      in    csr_we                 register index and data, no read-back
//
//  Regulating tick: restoring divide of COUNT_WIDTH+FRAC_BITS quotient bits for
//  the ratio, then deviation, write, average, control and output states; the average is a shift of the ring sum.
//  Idle or delayed tick: straight from idle to the output state.
//  Reset: synchronous, active high; history is cleared by a fill count, no pass.
//  The next word is taken while a result waits; a stalled result holds the
//  sequencer in its last state only.
// ----------------------------------------------------------------------------
module yarn_speed_ratio_regulator_core
   import ysrr_pkg::*;
#(
   parameter int FRAC_BITS     = 24,
   parameter int COUNT_WIDTH   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // running[0], count_a[16:1], count_b[32:17], zero[39:33]
   input  logic [39:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // led[0], fault_pin[1], motor_cmd[3:2], stepping[4], avg_deviation[36:5], zero[39:37]
   output logic [39:0]            rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW    = COUNT_WIDTH;
   localparam int QW    = COUNT_WIDTH + FRAC_BITS;
   localparam int SW    = 32 + HIST_SHIFT;
   localparam int CNTW  = $clog2(QW + 1);
   localparam int IW    = $clog2(HISTORY_DEPTH);
   localparam int FW    = $clog2(HISTORY_DEPTH + 1);
   localparam int DW    = (QW + 2 > 34) ? QW + 2 : 34;

   localparam logic [IW-1:0]        POS_LAST  = IW'(HISTORY_DEPTH - 1);
   localparam logic [FW-1:0]        FILL_FULL = FW'(HISTORY_DEPTH);
   localparam logic signed [DW-1:0] DEV_MAX   = {{(DW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [DW-1:0] DEV_MIN   = {{(DW-31){1'b1}}, {31{1'b0}}};
   localparam logic signed [DW-1:0] DEV_ONE   = DW'(1) << FRAC_BITS;

   // configuration
   logic        [7:0]  start_delay_ff;
   logic        [15:0] fault_delay_ff;
   logic        [23:0] up_thr_ff;
   logic signed [24:0] down_thr_ff;
   logic        [7:0]  left_step_ff;
   logic        [7:0]  right_step_ff;
   logic        [7:0]  pause_ff;
   logic signed [24:0] overfeed_ff;

   // control state
   state_type          state_ff,       state_in;
   logic               run_ff,         run_in;
   logic [7:0]         start_timer_ff, start_timer_in;
   logic [15:0]        fault_timer_ff, fault_timer_in;
   logic               latched_ff,     latched_in;
   logic               fault_out_ff,   fault_out_in;
   logic               led_ff,         led_in;
   motor_mode_type     mode_ff,        mode_in;
   logic [7:0]         step_ff,        step_in;
   logic [7:0]         pause_t_ff,     pause_t_in;
   logic [IW-1:0]      pos_ff,         pos_in;
   logic [FW-1:0]      fill_ff,        fill_in;
   logic signed [SW-1:0] sum_ff,       sum_in;
   logic [31:0]        avg_ff,         avg_in;
   logic [CNTW-1:0]    cnt_ff,         cnt_in;
   logic               rsp_tvalid_ff,  rsp_tvalid_in;

   // payload
   logic [QW-1:0]      num_ff,         num_in;
   logic [CW-1:0]      rem_ff,         rem_in;
   logic [CW-1:0]      divisor_ff,     divisor_in;
   logic [31:0]        dev_ff,         dev_in;
   logic [39:0]        rsp_tdata_ff,   rsp_tdata_in;

   // history memory
   logic [31:0]        hist_mem [HISTORY_DEPTH];
   logic [31:0]        mem_rd_ff;
   logic               mem_re;
   logic               mem_we;
   logic [IW-1:0]      pos_inc;

   // divider step
   logic [CW:0]        div_trial;
   logic [CW:0]        div_diff;
   logic               div_ge;

   logic               stop_take;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign pos_inc    = (pos_ff == POS_LAST) ? '0 : pos_ff + IW'(1);
   assign stop_take  = req_tvalid && req_tready && !req_tdata[0] && run_ff;

   assign div_trial = {rem_ff, num_ff[QW-1]};
   assign div_ge    = (div_trial >= {1'b0, divisor_ff});
   assign div_diff  = div_trial - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_delay_ff <= START_DELAY_RST;
         fault_delay_ff <= FAULT_DELAY_RST;
         up_thr_ff      <= UP_THR_RST;
         down_thr_ff    <= DOWN_THR_RST;
         left_step_ff   <= LEFT_STEP_RST;
         right_step_ff  <= RIGHT_STEP_RST;
         pause_ff       <= PAUSE_RST;
         overfeed_ff    <= OVERFEED_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_START_DELAY: start_delay_ff <= csr_wdata[7:0];
            REG_FAULT_DELAY: fault_delay_ff <= csr_wdata[15:0];
            REG_UP_THR:      up_thr_ff      <= csr_wdata[23:0];
            REG_DOWN_THR:    down_thr_ff    <= $signed(csr_wdata[24:0]);
            REG_LEFT_STEP:   left_step_ff   <= csr_wdata[7:0];
            REG_RIGHT_STEP:  right_step_ff  <= csr_wdata[7:0];
            REG_PAUSE:       pause_ff       <= csr_wdata[7:0];
            REG_OVERFEED:    overfeed_ff    <= $signed(csr_wdata[24:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[pos_inc] <= dev_ff;
      end
      if (mem_re) begin
         mem_rd_ff <= hist_mem[pos_inc];
      end
   end

   always_comb begin : seq
      logic [7:0]           st_v;
      logic                 run_v;
      logic [CW-1:0]        a_v;
      logic [CW-1:0]        b_v;
      logic signed [DW-1:0] q_v;
      logic signed [DW-1:0] ov_v;
      logic signed [DW-1:0] dev_v;
      logic [31:0]          old_v;
      logic [SW-1:0]        abs_v;
      logic [31:0]          mean_v;
      logic signed [32:0]   avg_s;
      logic signed [32:0]   up_s;
      logic signed [32:0]   down_s;
      logic [7:0]           s_v;
      logic [7:0]           p_v;
      logic [15:0]          ft_v;
      motor_mode_type       mode_v;
      logic                 lat_v;
      logic                 fo_v;

      state_in       = state_ff;
      run_in         = run_ff;
      start_timer_in = start_timer_ff;
      fault_timer_in = fault_timer_ff;
      latched_in     = latched_ff;
      fault_out_in   = fault_out_ff;
      led_in         = led_ff;
      mode_in        = mode_ff;
      step_in        = step_ff;
      pause_t_in     = pause_t_ff;
      pos_in         = pos_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      avg_in         = avg_ff;
      cnt_in         = cnt_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      dev_in         = dev_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      mem_re         = 1'b0;
      mem_we         = 1'b0;

      st_v   = (start_timer_ff != 8'd0) ? start_timer_ff - 8'd1 : 8'd0;
      run_v  = run_ff;
      a_v    = CW'(req_tdata[16:1]);
      b_v    = CW'(req_tdata[32:17]);
      if (a_v == '0) a_v = CW'(1);
      if (b_v == '0) b_v = CW'(1);
      q_v    = $signed(DW'(num_ff));
      ov_v   = $signed({{(DW-25){overfeed_ff[24]}}, overfeed_ff});
      dev_v  = q_v - DEV_ONE + ov_v;
      old_v  = (fill_ff == FILL_FULL) ? mem_rd_ff : 32'd0;
      abs_v  = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;
      mean_v = abs_v[SW-1:HIST_SHIFT];
      avg_s  = $signed({avg_ff[31], avg_ff});
      up_s   = $signed({9'd0, up_thr_ff});
      down_s = $signed({{8{down_thr_ff[24]}}, down_thr_ff});
      s_v    = step_ff;
      p_v    = (pause_t_ff != 8'd0) ? pause_t_ff - 8'd1 : 8'd0;
      ft_v   = fault_timer_ff;
      mode_v = mode_ff;
      lat_v  = latched_ff;
      fo_v   = fault_out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[0] && !run_ff) begin
                  fault_out_in   = 1'b0;
                  run_v          = 1'b1;
                  st_v           = start_delay_ff;
                  fault_timer_in = fault_delay_ff;
                  latched_in     = 1'b0;
               end
               if (!req_tdata[0] && run_ff) begin
                  led_in         = 1'b0;
                  pos_in         = '0;
                  fill_in        = '0;
                  sum_in         = '0;
                  avg_in         = '0;
                  run_v          = 1'b0;
                  latched_in     = 1'b0;
                  fault_timer_in = fault_delay_ff;
                  st_v           = 8'd0;
                  mode_in        = MODE_LOCKED;
               end
               run_in         = run_v;
               start_timer_in = st_v;
               if (run_v && st_v == 8'd0) begin
                  led_in     = !led_ff;
                  mem_re     = 1'b1;
                  num_in     = {a_v, {FRAC_BITS{1'b0}}};
                  rem_in     = '0;
                  divisor_in = b_v;
                  cnt_in     = CNTW'(QW);
                  state_in   = ST_RATIO;
               end else begin
                  state_in   = ST_OUT;
               end
            end
         end
         ST_RATIO: begin
            rem_in = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
            num_in = {num_ff[QW-2:0], div_ge};
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               state_in = ST_DEV;
            end
         end
         ST_DEV: begin
            if (dev_v > DEV_MAX) begin
               dev_in = 32'h7FFF_FFFF;
            end else if (dev_v < DEV_MIN) begin
               dev_in = 32'h8000_0000;
            end else begin
               dev_in = dev_v[31:0];
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            sum_in   = sum_ff - $signed({{(SW-32){old_v[31]}}, old_v})
                              + $signed({{(SW-32){dev_ff[31]}}, dev_ff});
            pos_in   = pos_inc;
            if (fill_ff != FILL_FULL) fill_in = fill_ff + FW'(1);
            state_in = ST_AVG;
         end
         ST_AVG: begin
            avg_in   = sum_ff[SW-1] ? (~mean_v + 32'd1) : mean_v;
            state_in = ST_CTRL;
         end
         ST_CTRL: begin
            if (step_ff != 8'd0) begin
               s_v = step_ff - 8'd1;
               if (s_v == 8'd0) p_v = pause_ff;
            end
            if (s_v == 8'd0) begin
               if (avg_s > down_s && avg_s < up_s) begin
                  ft_v   = fault_delay_ff;
                  mode_v = MODE_LOCKED;
               end else if (p_v == 8'd0) begin
                  if (avg_s >= up_s) begin
                     mode_v = MODE_LEFT;
                     s_v    = left_step_ff;
                  end else begin
                     mode_v = MODE_RIGHT;
                     s_v    = right_step_ff;
                  end
               end
            end
            if (mode_v != MODE_LOCKED && ft_v != 16'd0 && !lat_v) ft_v = ft_v - 16'd1;
            if (ft_v == 16'd0 && !lat_v) begin
               fo_v  = 1'b1;
               lat_v = 1'b1;
            end
            step_in        = s_v;
            pause_t_in     = p_v;
            fault_timer_in = ft_v;
            mode_in        = mode_v;
            latched_in     = lat_v;
            fault_out_in   = fo_v;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = {3'd0, avg_ff, (step_ff != 8'd0), mode_ff, fault_out_ff, led_ff};
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         run_ff         <= 1'b0;
         start_timer_ff <= 8'd0;
         fault_timer_ff <= FAULT_DELAY_RST;
         latched_ff     <= 1'b0;
         fault_out_ff   <= 1'b0;
         led_ff         <= 1'b0;
         mode_ff        <= MODE_LOCKED;
         step_ff        <= 8'd0;
         pause_t_ff     <= 8'd0;
         pos_ff         <= '0;
         fill_ff        <= '0;
         sum_ff         <= '0;
         avg_ff         <= '0;
         cnt_ff         <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         run_ff         <= run_in;
         start_timer_ff <= start_timer_in;
         fault_timer_ff <= fault_timer_in;
         latched_ff     <= latched_in;
         fault_out_ff   <= fault_out_in;
         led_ff         <= led_in;
         mode_ff        <= mode_in;
         step_ff        <= step_in;
         pause_t_ff     <= pause_t_in;
         pos_ff         <= pos_in;
         fill_ff        <= fill_in;
         sum_ff         <= sum_in;
         avg_ff         <= avg_in;
         cnt_ff         <= cnt_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      dev_ff       <= dev_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

`include "yarn_speed_ratio_regulator_core_assert.svh"

   `YSRR_ASSERT_NEXT(a_stop_clears_sum, clock, reset, stop_take, fill_ff == '0 && sum_ff == '0)
   `YSRR_ASSERT_NEXT(a_stop_clears_avg, clock, reset, stop_take, avg_ff == 32'd0)
   `YSRR_ASSERT_SAME(a_fault_from_ctrl, clock, reset, $rose(fault_out_ff), $past(state_ff) == ST_CTRL)
   `YSRR_ASSERT_SAME(a_rsp_from_out, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_OUT)
   `YSRR_ASSERT_SAME(a_div_count, clock, reset, state_ff == ST_RATIO, cnt_ff != '0)

endmodule
